// ----- rtl/core/bds_pkg.sv -----
`timescale 1ns / 1ps

package bds_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_CHANNELS   = 2'd0;
    localparam logic [1:0] REG_ROW_PIXELS = 2'd1;

    // Widths fixed by the register and field formats.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int SAMPLE_W   = 8;
    localparam int PAIR_W     = 9;

    // Depths of the command queue and the result queue.
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // One command from the front part to the back part.
    typedef struct packed {
        logic              emit;   // odd row: read the stored sum and emit
        logic              last;   // final byte of an output row
        logic [PAIR_W-1:0] pair;   // horizontal pair sum of this component
    } bds_cmd_t;

    // One result beat in the result queue.
    typedef struct packed {
        logic                row_last;
        logic [SAMPLE_W-1:0] value;
    } bds_out_t;

endpackage

// ----- rtl/core/bds_fifo.sv -----
`timescale 1ns / 1ps

module bds_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int P_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int C_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [P_W-1:0]   wr_ptr_reg;
    logic [P_W-1:0]   wr_ptr_next;
    logic [P_W-1:0]   rd_ptr_reg;
    logic [P_W-1:0]   rd_ptr_next;
    logic [C_W-1:0]   count_reg;
    logic [C_W-1:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == C_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = data_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == P_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == P_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/core/bds_front.sv -----
`timescale 1ns / 1ps

module bds_front
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int X_W          = 12,
    parameter int C_W          = 2,
    parameter int A_W          = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  cmd_push,
    output bds_cmd_t              cmd,
    output logic [A_W-1:0]        cmd_addr
);

    localparam int PROD_W   = X_W + 3;
    localparam int W_CAP    = MAX_WIDTH - (MAX_WIDTH % 2);
    // Reset settings are three channels and 4096 pixels, clamped like a write.
    localparam int CH_RESET = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;
    localparam int W_RESET  = (W_CAP < 4096) ? W_CAP : 4096;

    logic [2:0]          ch_eff_reg;
    logic [2:0]          ch_eff_next;
    logic [X_W-1:0]      w_last_reg;
    logic [X_W-1:0]      w_last_next;
    logic [X_W-1:0]      x_reg;
    logic [X_W-1:0]      x_next;
    logic [C_W-1:0]      c_reg;
    logic [C_W-1:0]      c_next;
    logic                odd_reg;
    logic                odd_next;
    logic [SAMPLE_W-1:0] held_reg [MAX_CHANNELS];
    logic [2:0]          ch_raw;
    logic [31:0]         w_raw;
    logic                c_last;
    logic                x_last;
    logic [PROD_W-1:0]   half;
    logic [PROD_W-1:0]   base;
    logic [PROD_W-1:0]   addr_full;

    // Effective settings, clamped once when a register is written.
    always_comb
    begin
        ch_raw = cfg_data[2:0];
        w_raw  = {19'd0, cfg_data[CFG_DATA_W-1:1], 1'b0};
        if (ch_raw == 3'd0)
        begin
            ch_raw = 3'd1;
        end
        else if (ch_raw > 3'(MAX_CHANNELS))
        begin
            ch_raw = 3'(MAX_CHANNELS);
        end
        if (w_raw < 32'd2)
        begin
            w_raw = 32'd2;
        end
        else if (w_raw > 32'(W_CAP))
        begin
            w_raw = 32'(W_CAP);
        end
    end

    assign c_last = (c_reg == C_W'(ch_eff_reg - 3'd1));
    assign x_last = (x_reg == w_last_reg);

    // Raster position: component, then pixel column, then row parity.
    always_comb
    begin
        ch_eff_next = ch_eff_reg;
        w_last_next = w_last_reg;
        x_next      = x_reg;
        c_next      = c_reg;
        odd_next    = odd_reg;
        if (cfg_we && (cfg_index == REG_CHANNELS || cfg_index == REG_ROW_PIXELS))
        begin
            if (cfg_index == REG_CHANNELS)
            begin
                ch_eff_next = ch_raw;
            end
            else
            begin
                w_last_next = X_W'(w_raw - 32'd1);
            end
            x_next   = '0;
            c_next   = '0;
            odd_next = 1'b0;
        end
        else if (in_valid)
        begin
            if (c_last)
            begin
                c_next = '0;
                if (x_last)
                begin
                    x_next   = '0;
                    odd_next = !odd_reg;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            else
            begin
                c_next = c_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_eff_reg <= 3'(CH_RESET);
            w_last_reg <= X_W'(W_RESET - 1);
            x_reg      <= '0;
            c_reg      <= '0;
            odd_reg    <= 1'b0;
        end
        else
        begin
            ch_eff_reg <= ch_eff_next;
            w_last_reg <= w_last_next;
            x_reg      <= x_next;
            c_reg      <= c_next;
            odd_reg    <= odd_next;
        end
    end

    // First component of each pixel pair, held per channel.
    always_ff @(posedge clk)
    begin
        if (in_valid && !x_reg[0])
        begin
            held_reg[c_reg] <= sample;
        end
    end

    // Line buffer address: pair number times channels plus component.
    always_comb
    begin
        half = PROD_W'(x_reg >> 1);
        case (ch_eff_reg)
            3'd1:    base = half;
            3'd2:    base = half << 1;
            3'd3:    base = (half << 1) + half;
            default: base = half << 2;
        endcase
        addr_full = base + PROD_W'(c_reg);
    end

    // The second pixel of a pair makes one command.
    assign cmd_push  = in_valid && x_reg[0];
    assign cmd.emit  = odd_reg;
    assign cmd.last  = x_last && c_last;
    assign cmd.pair  = {1'b0, held_reg[c_reg]} + {1'b0, sample};
    assign cmd_addr  = addr_full[A_W-1:0];

    // The position never leaves the configured raster.
    a_comp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_reg <= C_W'(ch_eff_reg - 3'd1))
        else $error("component index beyond channel count");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        x_reg <= w_last_reg)
        else $error("pixel column beyond row width");

endmodule

// ----- rtl/core/bds_back.sv -----
`timescale 1ns / 1ps

module bds_back
    import bds_pkg::*;
#(
    parameter int PAIR_DEPTH = 8192,
    parameter int A_W        = 13
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    input  bds_cmd_t                      cmd,
    input  logic [A_W-1:0]                cmd_addr,
    output logic                          cmd_pop,
    input  logic                          out_full,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                          out_push,
    output bds_out_t                      out_data
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [PAIR_W-1:0] pair_mem [PAIR_DEPTH];
    logic [PAIR_W-1:0] rd_data_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [PAIR_W-1:0] s1_pair_reg;
    logic              s1_last_reg;
    logic [CNT_W:0]    used;
    logic              space;
    logic [9:0]        total;
    logic [9:0]        rounded;

    // An emit command goes only when its result has a reserved slot.
    assign used    = {1'b0, out_count} + (CNT_W + 1)'(s1_valid_reg);
    assign space   = (used < (CNT_W + 1)'(OUT_DEPTH));
    assign cmd_pop = !cmd_empty && (!cmd.emit || space);

    // Line buffer: even rows write pair sums, odd rows read them back.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            if (cmd.emit)
            begin
                rd_data_reg <= pair_mem[cmd_addr];
            end
            else
            begin
                pair_mem[cmd_addr] <= cmd.pair;
            end
        end
    end

    assign s1_valid_next = cmd_pop && cmd.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
        begin
            s1_pair_reg <= cmd.pair;
            s1_last_reg <= cmd.last;
        end
    end

    // Block sum and rounding as (sum + 2) >> 2.
    assign total             = {1'b0, rd_data_reg} + {1'b0, s1_pair_reg};
    assign rounded           = total + 10'd2;
    assign out_push          = s1_valid_reg;
    assign out_data.value    = rounded[9:2];
    assign out_data.row_last = s1_last_reg;

    // The slot reservation keeps the result queue from overflowing.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !out_full)
        else $error("result pushed into a full queue");

    // Line buffer writes never wait on the result side.
    a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_empty && !cmd.emit) |-> cmd_pop)
        else $error("line buffer write stalled");

    // An emit held back is always due to a lack of result slots.
    a_emit_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_empty && cmd.emit && !cmd_pop) |-> (used >= (CNT_W + 1)'(OUT_DEPTH)))
        else $error("emit command stalled with free result slots");

endmodule

// ----- rtl/core/box_downsample_2x2_unit.sv -----
`timescale 1ns / 1ps

// 2x2 box downsampler for an interleaved 8-bit raster.
// Input channel: one component per beat on sample, taken when push is high
// and full is low. Components arrive in row order, pixel-interleaved.
// Result channel: value and row_last are valid while empty is low; the beat
// is taken when pop is high. row_last marks the final byte of an output row.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 channels,
// 1 row_pixels) at once; writing either restarts the raster at an even row.
// Write only while the block holds no unfinished beats.
// Throughput is one input beat per cycle while full is low. A front stage
// tracks the raster position and forms pair sums; a four-entry command queue
// feeds the back stage, whose single-port line buffer takes one command per
// cycle unless an emit waits for a result slot. An odd-row pair's command
// passes the line buffer read register into the result queue.
// Even rows and odd rows' first pixels of a pair produce no result.
// Reset restores channels 3 and row width 4096, empties both queues and
// clears the position; the line buffer keeps no reset value.
// When the receiver stalls, results collect in a four-entry queue, then the
// command queue fills and full rises until pop drains a beat.
module box_downsample_2x2_unit
    import bds_pkg::*;
#(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  empty,
    input  logic                  pop,
    output logic [SAMPLE_W-1:0]   value,
    output logic                  row_last
);

    localparam int X_W        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int C_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PAIR_DEPTH = (MAX_WIDTH / 2) * MAX_CHANNELS;
    localparam int A_W        = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int CMD_W      = A_W + $bits(bds_cmd_t);
    localparam int OUT_W      = $bits(bds_out_t);

    logic                           in_valid;
    logic                           cmd_push;
    bds_cmd_t                       front_cmd;
    logic [A_W-1:0]                 front_addr;
    logic [CMD_W-1:0]               cmdq_rdata;
    logic                           cmdq_empty;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmdq_count;
    logic                           cmd_pop;
    bds_cmd_t                       back_cmd;
    logic [A_W-1:0]                 back_addr;
    logic                           out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic                           out_push;
    bds_out_t                       out_wdata;
    bds_out_t                       out_rdata;
    logic                           out_empty;

    assign in_valid = push && !full;

    bds_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .X_W          (X_W),
        .C_W          (C_W),
        .A_W          (A_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .sample    (sample),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd),
        .cmd_addr  (front_addr)
    );

    // Command queue between the front and back parts.
    bds_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata ({front_addr, front_cmd}),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmdq_rdata),
        .empty (cmdq_empty),
        .count (cmdq_count)
    );

    assign back_cmd  = cmdq_rdata[$bits(bds_cmd_t)-1:0];
    assign back_addr = cmdq_rdata[CMD_W-1:$bits(bds_cmd_t)];

    bds_back #(
        .PAIR_DEPTH (PAIR_DEPTH),
        .A_W        (A_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmdq_empty),
        .cmd       (back_cmd),
        .cmd_addr  (back_addr),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_count (out_count),
        .out_push  (out_push),
        .out_data  (out_wdata)
    );

    // Result queue toward the receiver.
    bds_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (out_empty),
        .count (out_count)
    );

    assign empty    = out_empty;
    assign value    = out_rdata.value;
    assign row_last = out_rdata.row_last;

    // The command queue flags full exactly when its count reaches the depth.
    a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        full == (cmdq_count == ($clog2(CMD_DEPTH+1))'(CMD_DEPTH)))
        else $error("command queue full flag disagrees with its count");

endmodule
